/* rtl/core/uri_list_file_path_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// uri list file path decoder assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef URI_LIST_FILE_PATH_DECODER_TOP_MACROS_SVH
`define URI_LIST_FILE_PATH_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ULFPD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ulfpd port check failed");

// next-cycle implication, disabled in reset
`define ULFPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ulfpd port check failed");

`endif

/* rtl/core/ulfpd_pkg.sv */
// ----------------------------------------------------------------------------
// ulfpd_pkg
// types, constants and defaults for the uri list file path decoder
// ----------------------------------------------------------------------------
`default_nettype none

package ulfpd_pkg;

  localparam int unsigned MaxRes       = 5;
  localparam int unsigned CntW         = $clog2(MaxRes + 1);
  localparam int unsigned QueueDepthDf = 2;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChI     = 8'h69;
  localparam logic [7:0] ChL     = 8'h6C;
  localparam logic [7:0] ChE     = 8'h65;

  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_F      = 4'd1,
    PH_FI     = 4'd2,
    PH_FIL    = 4'd3,
    PH_FILE   = 4'd4,
    PH_COLON  = 4'd5,
    PH_SLASH1 = 4'd6,
    PH_HOST   = 4'd7,
    PH_PATH   = 4'd8,
    PH_SKIP   = 4'd9
  } line_phase_e;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HEX  = 2'd2
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       list_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] path_byte;
    logic       path_end;
  } out_word_t;

  typedef struct packed {
    logic [CntW-1:0]              cnt;
    out_word_t [MaxRes-1:0]       words;
  } bundle_t;

  typedef struct packed {
    logic        carr;
    line_phase_e ph;
    esc_phase_e  esc;
    logic [7:0]  hex;
    bundle_t     bnd;
  } acc_t;

endpackage

`default_nettype wire

/* rtl/core/ulfpd_front.sv */
// ----------------------------------------------------------------------------
// ulfpd_front
// line grammar and percent decoding; turns each input word into a bundle
// ----------------------------------------------------------------------------
`default_nettype none

module ulfpd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ulfpd_pkg::in_word_t in_word_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output ulfpd_pkg::bundle_t      bundle_o
);
  import ulfpd_pkg::*;

  logic        carr_q, carr_d;
  line_phase_e ph_q, ph_d;
  esc_phase_e  esc_q, esc_d;
  logic [7:0]  hex_q, hex_d;
  logic        accept;
  acc_t        acc;

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic acc_t emit(acc_t a, logic [7:0] b, logic e);
    acc_t r;
    r = a;
    if (r.bnd.cnt < CntW'(MaxRes)) begin
      r.bnd.words[r.bnd.cnt] = '{path_byte: b, path_end: e};
      r.bnd.cnt = r.bnd.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic acc_t path_char(acc_t a, logic [7:0] c);
    acc_t       r;
    logic [4:0] h;
    logic [4:0] hf;
    logic       done;
    r    = a;
    h    = hex_value(c);
    hf   = hex_value(a.hex);
    done = 1'b0;
    case (r.esc)
      ESC_PCT: begin
        if (h[4]) begin
          r.hex = c;
          r.esc = ESC_HEX;
          done  = 1'b1;
        end else begin
          r     = emit(r, ChPct, 1'b0);
          r.esc = ESC_NONE;
        end
      end
      ESC_HEX: begin
        if (h[4]) begin
          r     = emit(r, {hf[3:0], h[3:0]}, 1'b0);
          r.esc = ESC_NONE;
          done  = 1'b1;
        end else begin
          r     = emit(r, ChPct, 1'b0);
          r     = emit(r, r.hex, 1'b0);
          r.esc = ESC_NONE;
        end
      end
      default: r.esc = ESC_NONE;
    endcase
    if (!done) begin
      if (c == ChPct) r.esc = ESC_PCT;
      else r = emit(r, c, 1'b0);
    end
    return r;
  endfunction

  function automatic acc_t data_char(acc_t a, logic [7:0] c);
    acc_t r;
    r = a;
    unique case (r.ph)
      PH_START: begin
        if (c == ChSlash) begin
          r.ph = PH_PATH;
          r    = emit(r, ChSlash, 1'b0);
        end else if (c == ChF) begin
          r.ph = PH_F;
        end else begin
          r.ph = PH_SKIP;
        end
      end
      PH_F:     r.ph = (c == ChI) ? PH_FI : PH_SKIP;
      PH_FI:    r.ph = (c == ChL) ? PH_FIL : PH_SKIP;
      PH_FIL:   r.ph = (c == ChE) ? PH_FILE : PH_SKIP;
      PH_FILE:  r.ph = (c == ChColon) ? PH_COLON : PH_SKIP;
      PH_COLON: r.ph = (c == ChSlash) ? PH_SLASH1 : PH_HOST;
      PH_SLASH1: begin
        if (c == ChSlash) begin
          r.ph = PH_HOST;
        end else begin
          r.ph = PH_PATH;
          r    = emit(r, ChSlash, 1'b0);
          r    = path_char(r, c);
        end
      end
      PH_HOST: begin
        if (c == ChSlash) begin
          r.ph = PH_PATH;
          r    = emit(r, ChSlash, 1'b0);
        end
      end
      PH_PATH: r = path_char(r, c);
      default: r.ph = PH_SKIP;
    endcase
    return r;
  endfunction

  function automatic acc_t close_line(acc_t a);
    acc_t r;
    r = a;
    if (r.ph == PH_SLASH1) begin
      r = emit(r, ChSlash, 1'b0);
      r = emit(r, 8'd0, 1'b1);
    end else if (r.ph == PH_PATH) begin
      if (r.esc == ESC_PCT) begin
        r = emit(r, ChPct, 1'b0);
      end else if (r.esc == ESC_HEX) begin
        r = emit(r, ChPct, 1'b0);
        r = emit(r, r.hex, 1'b0);
      end
      r = emit(r, 8'd0, 1'b1);
    end
    r.ph   = PH_START;
    r.esc  = ESC_NONE;
    r.hex  = 8'd0;
    r.carr = 1'b0;
    return r;
  endfunction

  always_comb begin
    acc      = '0;
    acc.carr = carr_q;
    acc.ph   = ph_q;
    acc.esc  = esc_q;
    acc.hex  = hex_q;
    if (in_word_i.data_byte == ChLf) begin
      acc.carr = 1'b0;
      acc      = close_line(acc);
    end else if (in_word_i.data_byte == ChCr) begin
      if (acc.carr) acc = data_char(acc, ChCr);
      acc.carr = 1'b1;
      if (in_word_i.list_end) acc = close_line(acc);
    end else begin
      if (acc.carr) begin
        acc.carr = 1'b0;
        acc      = data_char(acc, ChCr);
      end
      acc = data_char(acc, in_word_i.data_byte);
      if (in_word_i.list_end) acc = close_line(acc);
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (acc.bnd.cnt != '0);
  assign bundle_o   = acc.bnd;

  always_comb begin
    carr_d = carr_q;
    ph_d   = ph_q;
    esc_d  = esc_q;
    hex_d  = hex_q;
    if (accept) begin
      carr_d = acc.carr;
      ph_d   = acc.ph;
      esc_d  = acc.esc;
      hex_d  = acc.hex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carr_q <= 1'b0;
      ph_q   <= PH_START;
      esc_q  <= ESC_NONE;
      hex_q  <= 8'd0;
    end else begin
      carr_q <= carr_d;
      ph_q   <= ph_d;
      esc_q  <= esc_d;
      hex_q  <= hex_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ulfpd_queue.sv */
// ----------------------------------------------------------------------------
// ulfpd_queue
// short bundle queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module ulfpd_queue #(
  parameter int unsigned Depth = ulfpd_pkg::QueueDepthDf
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ulfpd_pkg::bundle_t  bundle_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     valid_o,
  output ulfpd_pkg::bundle_t       bundle_o
);
  import ulfpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  bundle_t          mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o   = (fill_q == FillW'(Depth));
  assign valid_o  = (fill_q != '0);
  assign bundle_o = mem_q[rptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
    fill_d = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + 1'b1;
    else if (!do_push && do_pop) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= bundle_i;
  end

endmodule

`default_nettype wire

/* rtl/core/ulfpd_back.sv */
// ----------------------------------------------------------------------------
// ulfpd_back
// walks the head bundle and hands out one result word per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module ulfpd_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire ulfpd_pkg::bundle_t   head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ulfpd_pkg::out_word_t      out_word_o
);
  import ulfpd_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            xfer;
  logic            last;

  assign out_valid_o = head_valid_i;
  assign out_word_o  = head_i.words[idx_q];
  assign xfer        = out_valid_o && out_ready_i;
  assign last        = ((idx_q + 1'b1) == head_i.cnt);
  assign pop_o       = xfer && last;

  always_comb begin
    idx_d = idx_q;
    if (xfer) idx_d = last ? '0 : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/uri_list_file_path_decoder_top.sv */
// a byte's bundle is registered in the bundle queue and offered once it reaches the head
// throughput: one byte per cycle while each byte yields at most one word and the sink
// is ready; a byte yielding several words holds the output port for one transfer per word;
// a two-entry bundle queue between the decoder front and the output back absorbs the burst
// reset: rst_ni is asynchronous and active low; it returns the line to its start
// and empties the queue
// ----------------------------------------------------------------------------
// uri_list_file_path_decoder_top
// text uri list to decoded file path words, front, bundle queue and back
// ----------------------------------------------------------------------------
`default_nettype none

module uri_list_file_path_decoder_top #(
  parameter int unsigned QueueDepth = ulfpd_pkg::QueueDepthDf
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire ulfpd_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ulfpd_pkg::out_word_t      out_word_o
);
  import ulfpd_pkg::*;

  logic    q_full;
  logic    push;
  bundle_t push_bundle;
  logic    pop;
  logic    head_valid;
  bundle_t head_bundle;

  ulfpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  ulfpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (push_bundle),
    .full_o   (q_full),
    .pop_i    (pop),
    .valid_o  (head_valid),
    .bundle_o (head_bundle)
  );

  ulfpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_bundle),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

`default_nettype wire

/* rtl/core/ulfpd_checker.sv */
// ----------------------------------------------------------------------------
// ulfpd_checker
// port level checks on the decoder top, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "uri_list_file_path_decoder_top_macros.svh"

module ulfpd_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire ulfpd_pkg::in_word_t  in_word_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire ulfpd_pkg::out_word_t out_word_o
);
  import ulfpd_pkg::*;

  // stalled input word holds
  `ULFPD_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_word_i))

  // stalled word holds
  `ULFPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `ULFPD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_word_o))

  // an end marker carries no byte
  `ULFPD_ASSERT_IMPL(a_end_zero, out_valid_o && out_word_o.path_end,
                     out_word_o.path_byte == 8'd0)

  // output only appears after an input word was taken
  `ULFPD_ASSERT_IMPL(a_out_cause, $rose(out_valid_o), $past(in_valid_i && in_ready_o))

endmodule

bind uri_list_file_path_decoder_top ulfpd_checker u_ulfpd_checker (.*);

`default_nettype wire

/* sim/tb_uri_list_file_path_decoder_top.sv */
// ----------------------------------------------------------------------------
// tb_uri_list_file_path_decoder_top
// drives uri list text into the decoder one byte word at a time and checks
// every decoded path word against an in-bench line decoder, in order, under
// random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_uri_list_file_path_decoder_top;
  import ulfpd_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned DrainCycles = 8;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  uri_list_file_path_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #10 clk_i = ~clk_i;

  // line decoder state
  logic        cr_pending = 1'b0;
  line_phase_e line_ph = PH_START;
  esc_phase_e  esc_ph = ESC_NONE;
  logic [7:0]  held_hex = '0;
  int unsigned words_this_byte;

  out_word_t   path_words_due[$];
  logic [7:0]  line_bytes[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  bit          no_idle = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic put_path_word(input logic [7:0] b, input logic e);
    out_word_t w;
    if (words_this_byte < MaxRes) begin
      w.path_byte = b;
      w.path_end  = e;
      path_words_due = {path_words_due, w};
      words_this_byte++;
    end
  endtask

  task automatic decode_path_char(input logic [7:0] c);
    int h;
    h = hex_nibble(c);
    case (esc_ph)
      ESC_PCT: begin
        if (h >= 0) begin
          held_hex = c;
          esc_ph = ESC_HEX;
          return;
        end
        put_path_word(ChPct, 1'b0);
        esc_ph = ESC_NONE;
      end
      ESC_HEX: begin
        if (h >= 0) begin
          put_path_word(8'(hex_nibble(held_hex) * 16 + h), 1'b0);
          esc_ph = ESC_NONE;
          return;
        end
        put_path_word(ChPct, 1'b0);
        put_path_word(held_hex, 1'b0);
        esc_ph = ESC_NONE;
      end
      default: esc_ph = ESC_NONE;
    endcase
    if (c == ChPct) esc_ph = ESC_PCT;
    else put_path_word(c, 1'b0);
  endtask

  task automatic advance_line(input logic [7:0] c);
    case (line_ph)
      PH_START: begin
        if (c == ChSlash) begin
          line_ph = PH_PATH;
          put_path_word(ChSlash, 1'b0);
        end else if (c == ChF) line_ph = PH_F;
        else line_ph = PH_SKIP;
      end
      PH_F:     line_ph = (c == ChI) ? PH_FI : PH_SKIP;
      PH_FI:    line_ph = (c == ChL) ? PH_FIL : PH_SKIP;
      PH_FIL:   line_ph = (c == ChE) ? PH_FILE : PH_SKIP;
      PH_FILE:  line_ph = (c == ChColon) ? PH_COLON : PH_SKIP;
      PH_COLON: line_ph = (c == ChSlash) ? PH_SLASH1 : PH_HOST;
      PH_SLASH1: begin
        if (c == ChSlash) line_ph = PH_HOST;
        else begin
          line_ph = PH_PATH;
          put_path_word(ChSlash, 1'b0);
          decode_path_char(c);
        end
      end
      PH_HOST: begin
        if (c == ChSlash) begin
          line_ph = PH_PATH;
          put_path_word(ChSlash, 1'b0);
        end
      end
      PH_PATH: decode_path_char(c);
      default: line_ph = PH_SKIP;
    endcase
  endtask

  task automatic finish_line();
    if (line_ph == PH_SLASH1) begin
      put_path_word(ChSlash, 1'b0);
      put_path_word(8'h00, 1'b1);
    end else if (line_ph == PH_PATH) begin
      if (esc_ph == ESC_PCT) put_path_word(ChPct, 1'b0);
      else if (esc_ph == ESC_HEX) begin
        put_path_word(ChPct, 1'b0);
        put_path_word(held_hex, 1'b0);
      end
      put_path_word(8'h00, 1'b1);
    end
    line_ph = PH_START;
    esc_ph = ESC_NONE;
    held_hex = '0;
    cr_pending = 1'b0;
  endtask

  task automatic decode_byte(input in_word_t w);
    words_this_byte = 0;
    if (w.data_byte == ChLf) begin
      cr_pending = 1'b0;
      finish_line();
    end else if (w.data_byte == ChCr) begin
      if (cr_pending) advance_line(ChCr);
      cr_pending = 1'b1;
      if (w.list_end) finish_line();
    end else begin
      if (cr_pending) begin
        cr_pending = 1'b0;
        advance_line(ChCr);
      end
      advance_line(w.data_byte);
      if (w.list_end) finish_line();
    end
  endtask

  // monitor: check taken result words, predict on taken input words
  always @(posedge clk_i) begin
    out_word_t due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (path_words_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte %02h end %b",
                                    out_word_o.path_byte, out_word_o.path_end));
        end else begin
          due = path_words_due.pop_front();
          if (out_word_o.path_byte !== due.path_byte)
            report_mismatch($sformatf("path_byte got %02h want %02h",
                                      out_word_o.path_byte, due.path_byte));
          if (out_word_o.path_end !== due.path_end)
            report_mismatch($sformatf("path_end got %b want %b",
                                      out_word_o.path_end, due.path_end));
        end
      end
      if (in_valid_i && in_ready_o) decode_byte(in_word_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("uri_list_file_path_decoder_top: mismatch");
          $finish;
        end
      end
    end
  end

  // sink: random stall before each result word
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_word_i.data_byte <= b;
    in_word_i.list_end  <= last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit close_list);
    for (int i = 0; i < s.len(); i++) send_word(s[i], close_list && (i == s.len() - 1));
  endtask

  task automatic append_byte(input logic [7:0] b);
    line_bytes = {line_bytes, b};
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  function automatic logic [7:0] random_path_char();
    string hexset;
    hexset = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 9))
      0, 1:    return ChPct;
      2, 3:    return hexset[$urandom_range(0, 21)];
      4:       return ChCr;
      5:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  task automatic send_random_line();
    int unsigned len;
    bit          close_list;
    line_bytes.delete();
    len = $urandom_range(0, 10);
    case ($urandom_range(0, 11))
      0, 8:  queue_text("/");
      1, 9:  queue_text("file:///");
      2, 10: begin
        queue_text("file://");
        repeat ($urandom_range(0, 4)) append_byte(8'($urandom_range("a", "z")));
        queue_text("/");
      end
      3, 11: queue_text("file:/");
      4:     queue_text("#");
      5:     len = 0;
      6: begin
        queue_text("file://");
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range("a", "z")));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: queue_text("f");
          1: queue_text("fi");
          2: queue_text("fil");
          default: queue_text("file");
        endcase
      end
    endcase
    repeat (len) append_byte(random_path_char());
    close_list = 1'b0;
    case ($urandom_range(0, 3))
      0: append_byte(ChLf);
      1: begin
        append_byte(ChCr);
        append_byte(ChLf);
      end
      2: begin
        if (line_bytes.size() == 0) append_byte(ChLf);
        close_list = 1'b1;
      end
      default: begin
        append_byte(ChCr);
        close_list = 1'b1;
      end
    endcase
    foreach (line_bytes[i]) send_word(line_bytes[i], close_list && (i == line_bytes.size() - 1));
  endtask

  task automatic test_plain_path();
    send_text("/", 1'b0);
    send_word(8'h00, 1'b0);
    send_text("%4A\n", 1'b0);
  endtask

  task automatic test_file_host_uri();
    send_text("file://h/", 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("%g\r", 1'b1);
  endtask

  task automatic test_skipped_lines();
    send_text("#\n", 1'b0);
    send_text("\n", 1'b0);
  endtask

  task automatic test_escape_at_line_end();
    send_text("/%\n", 1'b1);
  endtask

  task automatic test_prefix_only();
    send_text("file:", 1'b1);
  endtask

  task automatic test_random_lists();
    int unsigned stop_at;
    stop_at = bytes_sent + 220;
    while (bytes_sent < stop_at) begin
      no_idle = ($urandom_range(0, 3) == 0);
      send_random_line();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_noise();
    repeat (30) send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_plain_path();
    test_file_host_uri();
    test_skipped_lines();
    test_escape_at_line_end();
    test_prefix_only();
    test_random_lists();
    test_noise();
    in_valid_i <= 1'b0;
    while (path_words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (path_words_due.size() != 0)
      report_mismatch($sformatf("%0d path words never arrived", path_words_due.size()));
    if (error_count == 0) begin
      $display("uri_list_file_path_decoder_top: match");
    end else begin
      $display("uri_list_file_path_decoder_top: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ulfpd_pkg.sv
rtl/core/ulfpd_front.sv
rtl/core/ulfpd_queue.sv
rtl/core/ulfpd_back.sv
rtl/core/uri_list_file_path_decoder_top.sv
rtl/core/ulfpd_checker.sv
sim/tb_uri_list_file_path_decoder_top.sv
